// ===== rtl/slpm_pkg.sv =====
`default_nettype none
package slpm_pkg;

  // pattern symbols
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_ASTERISK   = 8'h2A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_QUESTION   = 8'h3F;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 6;

  // kind of pattern token starting at a position
  typedef enum logic [2:0] {
    K_STAR,
    K_ONE,
    K_LIT1,
    K_LIT2,
    K_DEAD
  } kind_t;

  // token write from the parser into one cell, or a clear of every cell
  typedef struct packed {
    logic       clear;
    kind_t      kind;
    logic [1:0] off;
    logic [7:0] lit_a;
    logic [7:0] lit_b;
  } cell_wr_t;

endpackage
`default_nettype wire

// ===== rtl/slpm_cell.sv =====
`default_nettype none
module slpm_cell (
  input  logic              clk,
  input  logic              rst,
  input  slpm_pkg::cell_wr_t wr,
  input  logic              load,
  input  logic              cur,
  input  logic              two,
  input  logic [7:0]        a,
  input  logic [7:0]        b,
  output logic              star,
  output logic              stay,
  output logic [2:0]        hit
);
  import slpm_pkg::*;

  kind_t      kind;
  logic [1:0] off;
  logic [7:0] lit_a;
  logic [7:0] lit_b;
  logic       matched;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= K_DEAD;
    end else if (wr.clear) begin
      kind <= K_DEAD;
    end else if (load) begin
      kind <= wr.kind;
    end
    if (load) begin
      off   <= wr.off;
      lit_a <= wr.lit_a;
      lit_b <= wr.lit_b;
    end
  end

  always_comb begin
    case (kind)
      K_ONE:   matched = 1'b1;
      K_LIT1:  matched = !two && (a == lit_a);
      K_LIT2:  matched = two && (a == lit_a) && (b == lit_b);
      default: matched = 1'b0;
    endcase
  end

  assign star = (kind == K_STAR);
  assign stay = cur && star;

  // hit lands one, two or three positions further on
  assign hit[0] = cur && matched && (off == 2'd1);
  assign hit[1] = cur && matched && (off == 2'd2);
  assign hit[2] = cur && matched && (off == 2'd3);

endmodule
`default_nettype wire

// ===== rtl/slpm_parser.sv =====
`default_nettype none
module slpm_parser #(
  parameter int unsigned PATTERN_MAX_BYTES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [PATTERN_MAX_BYTES*8-1:0]       pat,
  input  logic [$clog2(PATTERN_MAX_BYTES+1)-1:0] eff_len,
  output logic                                 busy,
  output slpm_pkg::cell_wr_t                   wr,
  output logic [PATTERN_MAX_BYTES-1:0]         load_sel
);
  import slpm_pkg::*;

  localparam int unsigned PW = $clog2(PATTERN_MAX_BYTES + 4);

  typedef enum logic [1:0] {
    P_IDLE,
    P_LOAD,
    P_SCAN
  } pstate_t;

  pstate_t                        state;
  logic [PW-1:0]                  pos;
  logic [PATTERN_MAX_BYTES*8-1:0] win;

  logic [PW:0] pos_x;
  logic [PW:0] len_x;
  logic [7:0]  c0;
  logic [7:0]  c1;
  logic [7:0]  c2;
  logic [7:0]  lc;
  logic [7:0]  tail;
  logic        esc;
  logic        avail;
  logic        done;
  logic        step;

  assign c0    = win[7:0];
  assign c1    = win[15:8];
  assign c2    = win[23:16];
  assign pos_x = {1'b0, pos};
  assign len_x = (PW+1)'(eff_len);
  assign done  = (pos_x >= len_x);
  assign step  = (state == P_SCAN) && !done && !cfg_we;

  // a trailing backslash stays a literal
  assign esc   = (c0 == CH_BACKSLASH) && (pos_x + (PW+1)'(1) < len_x);
  assign lc    = esc ? c1 : c0;
  assign tail  = esc ? c2 : c1;
  assign avail = (pos_x + (esc ? (PW+1)'(2) : (PW+1)'(1)) < len_x);

  always_comb begin
    wr.clear = (state == P_LOAD);
    wr.lit_a = lc;
    wr.lit_b = tail;
    if (c0 == CH_PERCENT || c0 == CH_ASTERISK) begin
      wr.kind = K_STAR;
      wr.off  = 2'd1;
    end else if (c0 == CH_UNDERSCORE || c0 == CH_QUESTION) begin
      wr.kind = K_ONE;
      wr.off  = 2'd1;
    end else if (lc[7] && avail) begin
      wr.kind = K_LIT2;
      wr.off  = esc ? 2'd3 : 2'd2;
    end else if (lc[7]) begin
      // lead byte with nothing after it
      wr.kind = K_DEAD;
      wr.off  = esc ? 2'd2 : 2'd1;
    end else begin
      wr.kind = K_LIT1;
      wr.off  = esc ? 2'd2 : 2'd1;
    end
  end

  for (genvar i = 0; i < PATTERN_MAX_BYTES; i++) begin : g_sel
    assign load_sel[i] = step && (pos == PW'(i));
  end

  assign busy = (state != P_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      pos   <= '0;
    end else if (cfg_we) begin
      state <= P_LOAD;
    end else begin
      case (state)
        P_LOAD: begin
          state <= P_SCAN;
          pos   <= '0;
        end
        P_SCAN: begin
          if (done) begin
            state <= P_IDLE;
          end else begin
            pos <= pos + PW'(wr.off);
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  // window slides so the current token is always in the low bytes
  always_ff @(posedge clk) begin
    if (state == P_LOAD) begin
      win <= pat;
    end else if (step) begin
      case (wr.off)
        2'd1:    win <= win >> 8;
        2'd2:    win <= win >> 16;
        default: win <= win >> 24;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sql_like_pattern_matcher.sv =====
`default_nettype none
// channel   dir  signals                        beat content
// s_*       in   s_tvalid s_tready s_tdata s_tlast  text_byte, end_of_text on tlast
// m_*       out  m_tvalid m_tready m_tdata      is_match in bit 0
// cfg_*     in   cfg_we cfg_index cfg_data      register write, no handshake
//
// one text beat per cycle while s_tready is high; the position set of the cell row is
// updated in the cycle the beat is taken (a lead byte is held for the next beat), and
// an end beat's verdict goes to the output register, or to the skid register if stalled
// a config write starts a token scan of the pattern, one token per cycle between
// writes; s_tready is low during it and while output and skid registers are full
// rst is synchronous; after it the pattern is empty and only position 0 is live
module sql_like_pattern_matcher #(
  parameter int unsigned PATTERN_MAX_BYTES = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] text_byte
  input  logic                               s_tlast,   // end_of_text
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,   // [0] is_match, rest zero
  input  logic                               cfg_we,
  input  logic [slpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slpm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import slpm_pkg::*;

  localparam int unsigned NP = PATTERN_MAX_BYTES + 1;
  localparam int unsigned LW = $clog2(PATTERN_MAX_BYTES + 1);
  localparam logic [NP-1:0] ACT_START = NP'(1);

  // configuration
  logic [PATTERN_MAX_BYTES*8-1:0] pat;
  logic [LEN_W-1:0]               len_reg;
  logic [LW-1:0]                  eff_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat     <= '0;
      len_reg <= '0;
    end else if (cfg_we) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 8; k++) begin
          if (r*8 + k < PATTERN_MAX_BYTES && cfg_index == CFG_IDX_W'(r)) begin
            pat[(r*8+k)*8 +: 8] <= cfg_data[k*8 +: 8];
          end
        end
      end
      if (cfg_index == REG_PAT_LEN) begin
        len_reg <= cfg_data[LEN_W-1:0];
      end
    end
  end

  assign eff_len = (32'(len_reg) > PATTERN_MAX_BYTES) ? LW'(PATTERN_MAX_BYTES)
                                                       : LW'(len_reg);

  // pattern scan into the cell row
  logic                         busy;
  cell_wr_t                     wr;
  logic [PATTERN_MAX_BYTES-1:0] load_sel;

  slpm_parser #(
    .PATTERN_MAX_BYTES(PATTERN_MAX_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .pat     (pat),
    .eff_len (eff_len),
    .busy    (busy),
    .wr      (wr),
    .load_sel(load_sel)
  );

  // matching state
  logic [NP-1:0] active;
  logic [7:0]    held;
  logic          waiting;

  // star closure as a carry chain: live bit runs forward through star cells
  logic [PATTERN_MAX_BYTES-1:0] star;
  logic [NP:0]   cl_p;
  logic [NP:0]   cl_a;
  logic [NP:0]   cl_b;
  logic [NP:0]   cl_s;
  logic [NP:0]   cl_c;
  logic [NP-1:0] closed;

  assign cl_p   = {1'b0, star, 1'b0};
  assign cl_b   = {1'b0, active};
  assign cl_a   = cl_b | cl_p;
  assign cl_s   = cl_a + cl_b;
  assign cl_c   = cl_s ^ cl_a ^ cl_b;
  assign closed = cl_c[NP:1];

  logic                         two;
  logic [7:0]                   ch_a;
  logic [PATTERN_MAX_BYTES-1:0] stay;
  logic [2:0]                   hit [PATTERN_MAX_BYTES];
  logic [NP-1:0]                nxt;

  assign two  = waiting;
  assign ch_a = waiting ? held : s_tdata;

  for (genvar i = 0; i < PATTERN_MAX_BYTES; i++) begin : g_cell
    slpm_cell u_cell (
      .clk (clk),
      .rst (rst),
      .wr  (wr),
      .load(load_sel[i]),
      .cur (closed[i]),
      .two (two),
      .a   (ch_a),
      .b   (s_tdata),
      .star(star[i]),
      .stay(stay[i]),
      .hit (hit[i])
    );
  end

  always_comb begin
    nxt = '0;
    for (int i = 0; i < PATTERN_MAX_BYTES; i++) begin
      nxt[i] = nxt[i] | stay[i];
      for (int k = 0; k < 3; k++) begin
        if (i + k + 1 <= PATTERN_MAX_BYTES) begin
          nxt[i+k+1] = nxt[i+k+1] | hit[i][k];
        end
      end
    end
  end

  // handshake and result buffering
  logic s_acc;
  logic res_new;
  logic res_bit;
  logic skid_valid;
  logic skid_bit;
  logic out_bit;

  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = !busy && !cfg_we && !skid_valid;
  assign res_new  = s_acc && s_tlast;
  assign res_bit  = !waiting && closed[eff_len];
  assign m_tdata  = {7'd0, out_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= ACT_START;
      held    <= '0;
      waiting <= 1'b0;
    end else if (s_acc) begin
      if (s_tlast) begin
        active  <= ACT_START;
        held    <= '0;
        waiting <= 1'b0;
      end else if (waiting) begin
        active  <= nxt;
        held    <= '0;
        waiting <= 1'b0;
      end else if (s_tdata[7]) begin
        held    <= s_tdata;
        waiting <= 1'b1;
      end else begin
        active <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= res_new;
      end
    end else if (res_new) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_bit <= skid_valid ? skid_bit : res_bit;
    end else if (res_new) begin
      skid_bit <= res_bit;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a verdict while output register is empty");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tlast) |=> (active == ACT_START && !waiting))
    else $error("state not restarted after end beat");

  a_end_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tlast) |=> m_tvalid)
    else $error("end beat gave no verdict");

  a_held_is_lead: assert property (@(posedge clk) disable iff (rst)
    waiting |-> held[7])
    else $error("held byte is not a lead byte");

  a_no_take_while_scan: assert property (@(posedge clk) disable iff (rst)
    (busy && !$past(cfg_we)) |-> !s_acc)
    else $error("text beat taken during pattern scan");

endmodule
`default_nettype wire
